// ===== rtl/lle_pkg.sv =====
// Package with the shared constants, codes and structs of the pooled linked list engine.
`timescale 1ns / 1ps

package lle_pkg;

   // Pool size and index widths. An index of NODES means "no node".
   localparam int NODES  = 32;
   localparam int IDX_W  = 6;
   localparam int ADDR_W = 5;
   localparam int ID_W   = 32;
   localparam int MARK_W = 32;

   localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(NODES);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_NOSUCC = 2'd3
   } status_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   // Two write ports into the link store; port 1 wins on a clash.
   typedef struct packed {
      logic              en0;
      logic [ADDR_W-1:0] addr0;
      logic [IDX_W-1:0]  data0;
      logic              en1;
      logic [ADDR_W-1:0] addr1;
      logic [IDX_W-1:0]  data1;
   } link_write_type;

   // Links read from the store before the operation changes anything.
   typedef struct packed {
      logic [IDX_W-1:0] free_next;
      logic [IDX_W-1:0] head_next;
      logic [IDX_W-1:0] pred_next;
      logic [IDX_W-1:0] succ_next;
   } link_reads_type;

   // Everything one operation decides.
   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  node;
      logic [IDX_W-1:0]  list_head;
      logic [IDX_W-1:0]  free_head;
      logic [IDX_W-1:0]  count;
      logic              store_en;
      logic [ADDR_W-1:0] store_addr;
   } op_result_type;

endpackage

// ===== rtl/lle_link_file.sv =====
// Link store register file with its reset image, read ports and two write ports.
`timescale 1ns / 1ps

module lle_link_file import lle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] free_head,
   input  logic [IDX_W-1:0] list_head,
   input  logic [IDX_W-1:0] pred_index,
   input  link_write_type   wr,
   output link_reads_type   rd
);

   logic [NODES-1:0][IDX_W-1:0] link_ff;

   // Anything out of range reads as no node.
   function automatic logic [IDX_W-1:0] read_link(
      input logic [NODES-1:0][IDX_W-1:0] links,
      input logic [IDX_W-1:0]            idx
   );
      logic [IDX_W-1:0] val;
      val = NONE_IDX;
      if (idx < NONE_IDX) begin
         val = links[idx[ADDR_W-1:0]];
      end
      return val;
   endfunction

   always_comb begin
      rd.free_next = read_link(link_ff, free_head);
      rd.head_next = read_link(link_ff, list_head);
      rd.pred_next = read_link(link_ff, pred_index);
      rd.succ_next = read_link(link_ff, rd.pred_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            link_ff[i] <= (i == NODES - 1) ? NONE_IDX : IDX_W'(i + 1);
         end
      end else begin
         if (wr.en0) begin
            link_ff[wr.addr0] <= wr.data0;
         end
         if (wr.en1) begin
            link_ff[wr.addr1] <= wr.data1;
         end
      end
   end

endmodule

// ===== rtl/lle_op_logic.sv =====
// Combinational insert and delete decisions for one list operation.
`timescale 1ns / 1ps

module lle_op_logic import lle_pkg::*; (
   input  logic             fire,
   input  kind_type         kind,
   input  logic [IDX_W-1:0] pred_index,
   input  logic [IDX_W-1:0] list_head,
   input  logic [IDX_W-1:0] free_head,
   input  logic [IDX_W-1:0] count,
   input  link_reads_type   rd,
   output link_write_type   wr,
   output op_result_type    res
);

   logic has_pred;

   assign has_pred = pred_index < NONE_IDX;

   always_comb begin
      wr             = '0;
      res.status     = ST_OK;
      res.node       = NONE_IDX;
      res.list_head  = list_head;
      res.free_head  = free_head;
      res.count      = count;
      res.store_en   = 1'b0;
      res.store_addr = free_head[ADDR_W-1:0];

      case (kind)
         KIND_INSERT: begin
            if (free_head >= NONE_IDX) begin
               res.status = ST_FULL;
            end else begin
               // Take the node at the free head.
               res.free_head = rd.free_next;
               res.node      = free_head;
               res.store_en  = fire;
               wr.en0        = fire;
               wr.addr0      = free_head[ADDR_W-1:0];
               if (!has_pred) begin
                  wr.data0      = list_head;
                  res.list_head = free_head;
               end else begin
                  wr.data0 = rd.pred_next;
                  wr.en1   = fire;
                  wr.addr1 = pred_index[ADDR_W-1:0];
                  wr.data1 = free_head;
               end
               if (count < NONE_IDX) begin
                  res.count = count + IDX_W'(1);
               end
            end
         end
         KIND_DELETE: begin
            if (list_head >= NONE_IDX) begin
               res.status = ST_EMPTY;
            end else if (!has_pred) begin
               res.list_head = rd.head_next;
               res.free_head = list_head;
               res.node      = list_head;
               wr.en0        = fire;
               wr.addr0      = list_head[ADDR_W-1:0];
               wr.data0      = free_head;
               if (count != '0) begin
                  res.count = count - IDX_W'(1);
               end
            end else if (rd.pred_next >= NONE_IDX) begin
               res.status = ST_NOSUCC;
            end else begin
               // Unlink the successor first, then push it on the free list.
               wr.en0        = fire;
               wr.addr0      = pred_index[ADDR_W-1:0];
               wr.data0      = rd.succ_next;
               wr.en1        = fire;
               wr.addr1      = rd.pred_next[ADDR_W-1:0];
               wr.data1      = free_head;
               res.free_head = rd.pred_next;
               res.node      = rd.pred_next;
               if (count != '0) begin
                  res.count = count - IDX_W'(1);
               end
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
   end

endmodule

// ===== rtl/pooled_linked_list_engine.sv =====
// Top level of the pooled linked list engine: word registers, list state and node payload store.
`timescale 1ns / 1ps
// A word accepted into the input register has its result word in the output register once the
// operation completes. Throughput: one word per cycle while responses drain, set by the single
// pass of the operation logic over the link register file between the input and output registers.
// Reset (synchronous, active high) empties the list, threads every node onto the free list in
// index order and clears both word registers; node payloads are undefined until written.

module pooled_linked_list_engine import lle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // pred_index[5:0], student_id[37:6], mark_bits[69:38]
   input  logic [0:0]  req_tuser,   // kind[0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // node_index[5:0], head_index[11:6], element_count[17:12]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   // Input register: holds one request word until the operation can complete.
   logic                     stage_valid_ff;
   kind_type                 stage_kind_ff;
   logic [IDX_W-1:0]         stage_pred_ff;
   logic signed [ID_W-1:0]   stage_sid_ff;
   logic [MARK_W-1:0]        stage_mark_ff;

   // List state.
   logic [IDX_W-1:0]         list_head_ff;
   logic [IDX_W-1:0]         free_head_ff;
   logic [IDX_W-1:0]         count_ff;

   // Output register.
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [IDX_W-1:0]         rsp_node_ff;
   logic [IDX_W-1:0]         rsp_head_ff;
   logic [IDX_W-1:0]         rsp_count_ff;

   // Node payload store; written on every successful insert.
   logic signed [ID_W-1:0]   id_mem   [NODES];
   logic [MARK_W-1:0]        mark_mem [NODES];

   logic                     advance;
   logic                     req_fire;
   link_reads_type           link_rd;
   link_write_type           link_wr;
   op_result_type            op_res;

   // The operation completes when the output register is empty or being drained. A response
   // word held back by the receiver stalls the operation, and the input register then takes
   // a new word only in the cycle that the response drains.
   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   lle_link_file u_link_file (
      .clock      (clock),
      .reset      (reset),
      .free_head  (free_head_ff),
      .list_head  (list_head_ff),
      .pred_index (stage_pred_ff),
      .wr         (link_wr),
      .rd         (link_rd)
   );

   lle_op_logic u_op_logic (
      .fire       (advance),
      .kind       (stage_kind_ff),
      .pred_index (stage_pred_ff),
      .list_head  (list_head_ff),
      .free_head  (free_head_ff),
      .count      (count_ff),
      .rd         (link_rd),
      .wr         (link_wr),
      .res        (op_res)
   );

   // Control state and list state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         list_head_ff   <= NONE_IDX;
         free_head_ff   <= '0;
         count_ff       <= '0;
      end else begin
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            list_head_ff <= op_res.list_head;
            free_head_ff <= op_res.free_head;
            count_ff     <= op_res.count;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers of the two word stages.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_kind_ff <= kind_type'(req_tuser[0]);
         stage_pred_ff <= req_tdata[5:0];
         stage_sid_ff  <= $signed(req_tdata[37:6]);
         stage_mark_ff <= req_tdata[69:38];
      end
      if (advance) begin
         rsp_status_ff <= op_res.status;
         rsp_node_ff   <= op_res.node;
         rsp_head_ff   <= op_res.list_head;
         rsp_count_ff  <= op_res.count;
      end
   end

   always_ff @(posedge clock) begin
      if (op_res.store_en) begin
         id_mem[op_res.store_addr]   <= stage_sid_ff;
         mark_mem[op_res.store_addr] <= stage_mark_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_head_ff, rsp_node_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
